### sv/csvft_pkg.sv
`timescale 1ns / 1ps
package csvft_pkg;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef logic [2:0] act_type;

   // what one input item does
   localparam act_type ACT_NONE    = 3'd0;
   localparam act_type ACT_HOLD    = 3'd1;
   localparam act_type ACT_DROP    = 3'd2;
   localparam act_type ACT_CONTENT = 3'd3;
   localparam act_type ACT_FIELD   = 3'd4;
   localparam act_type ACT_LINE    = 3'd5;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       line_end;
      logic       space_overflow;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    load;
      logic    decide;
      logic    rd_start;
      logic    rd_en;
      logic    emit_space;
      logic    emit_final;
      act_type act;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    count_zero;
      logic    flush_last;
      logic    out_free;
   } status_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

endpackage

### sv/csvft_req_if.sv
`timescale 1ns / 1ps
interface csvft_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_byte;

   modport source (output valid, output kind, output char_byte, input ready);
   modport sink (input valid, input kind, input char_byte, output ready);
endinterface

### sv/csvft_rsp_if.sv
`timescale 1ns / 1ps
interface csvft_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       field_end;
   logic       line_end;
   logic       space_overflow;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output field_end,
                   output line_end, output space_overflow, output last, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input field_end,
                 input line_end, input space_overflow, input last, output ready);
endinterface

### sv/csvft_ram.sv
`timescale 1ns / 1ps
module csvft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/csvft_dp.sv
`timescale 1ns / 1ps
module csvft_dp
   import csvft_pkg::*;
#(
   parameter int MAX_PENDING_SPACE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       req_kind,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int CW = $clog2(MAX_PENDING_SPACE + 1);
   localparam int AW = (MAX_PENDING_SPACE > 1) ? $clog2(MAX_PENDING_SPACE) : 1;

   logic          item_kind_ff;
   logic [7:0]    item_char_ff;
   logic          quoted_ff, quoted_in;
   logic          pending_ff, pending_in;
   logic          text_seen_ff, text_seen_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   act_type       act;
   logic          use_content;
   logic [7:0]    space_byte;
   logic          ram_wr_en;

   // classify the held item against the quote and trim state
   always_comb begin
      act         = ACT_NONE;
      quoted_in   = quoted_ff;
      pending_in  = pending_ff;
      use_content = 1'b0;
      if (item_kind_ff) begin
         act        = ACT_LINE;
         quoted_in  = 1'b0;
         pending_in = 1'b0;
      end else if (pending_ff) begin
         pending_in = 1'b0;
         if (item_char_ff == CHAR_QUOTE) begin
            use_content = 1'b1;
         end else begin
            quoted_in = 1'b0;
            if (item_char_ff == CHAR_COMMA) begin
               act = ACT_FIELD;
            end else begin
               use_content = 1'b1;
            end
         end
      end else if (item_char_ff == CHAR_QUOTE) begin
         if (quoted_ff) begin
            pending_in = 1'b1;
         end else begin
            quoted_in = 1'b1;
         end
      end else if ((item_char_ff == CHAR_COMMA) && !quoted_ff) begin
         act = ACT_FIELD;
      end else begin
         use_content = 1'b1;
      end
      if (use_content) begin
         if (is_space(item_char_ff)) begin
            if (text_seen_ff) begin
               act = (count_ff < CW'(MAX_PENDING_SPACE)) ? ACT_HOLD : ACT_DROP;
            end
         end else begin
            act = ACT_CONTENT;
         end
      end
   end

   always_comb begin
      text_seen_in = text_seen_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      if (cmd.decide && (cmd.act == ACT_HOLD)) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.decide && (cmd.act == ACT_DROP)) begin
         ovf_in = 1'b1;
      end
      if (cmd.emit_final) begin
         count_in = '0;
         if (cmd.act == ACT_CONTENT) begin
            text_seen_in = 1'b1;
         end else begin
            text_seen_in = 1'b0;
            ovf_in       = 1'b0;
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.rd_start) begin
         idx_in = '0;
      end else if (cmd.emit_space) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit_space) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in                = '0;
         rsp_data_in.out_byte       = space_byte;
         rsp_data_in.byte_valid     = 1'b1;
      end else if (cmd.emit_final) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in                = '0;
         rsp_data_in.last           = 1'b1;
         if (cmd.act == ACT_CONTENT) begin
            rsp_data_in.out_byte    = item_char_ff;
            rsp_data_in.byte_valid  = 1'b1;
         end else begin
            rsp_data_in.field_end      = 1'b1;
            rsp_data_in.line_end       = (cmd.act == ACT_LINE);
            rsp_data_in.space_overflow = ovf_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         text_seen_ff <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.decide) begin
            quoted_ff  <= quoted_in;
            pending_ff <= pending_in;
         end
         text_seen_ff <= text_seen_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_kind_ff <= req_kind;
         item_char_ff <= req_char_byte;
      end
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign ram_wr_en = cmd.decide && (cmd.act == ACT_HOLD);

   csvft_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PENDING_SPACE)
   ) u_space_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (item_char_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (space_byte)
   );

   assign status.act        = act;
   assign status.count_zero = (count_ff == '0);
   assign status.flush_last = ((idx_ff + CW'(1)) == count_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/csvft_ctrl.sv
`timescale 1ns / 1ps
module csvft_ctrl
   import csvft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SPACE  = 3'd3;
   localparam logic [2:0] S_FINAL  = 3'd4;

   logic [2:0] state_ff, state_in;
   act_type    act_ff, act_in;

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.act   = act_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            cmd.act    = status.act;
            act_in     = status.act;
            unique case (status.act)
               ACT_CONTENT: begin
                  if (status.count_zero) begin
                     state_in = S_FINAL;
                  end else begin
                     // held inner whitespace goes out ahead of the byte
                     cmd.rd_start = 1'b1;
                     state_in     = S_READ;
                  end
               end
               ACT_FIELD, ACT_LINE: state_in = S_FINAL;
               default:             state_in = S_IDLE;
            endcase
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SPACE;
         end
         S_SPACE: begin
            if (status.out_free) begin
               cmd.emit_space = 1'b1;
               state_in       = status.flush_last ? S_FINAL : S_READ;
            end
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff   <= ACT_NONE;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
      end
   end

endmodule

### sv/csv_field_tokenizer_top.sv
`timescale 1ns / 1ps
// channel    modport  beat
// req_chan   sink     kind, char_byte (one byte or an end of line)
// rsp_chan   source   out_byte, byte_valid, field_end, line_end, space_overflow, last
//
// one item at a time: accept, decide, then emit each result once rsp_chan is free
// each held whitespace byte that is released is read from the space ram, then output
// synchronous active-high reset clears quote, trim and handshake state; the space ram is not cleared
// req_chan.ready is high only while idle; a result waits in the output register under stall
module csv_field_tokenizer_top
   import csvft_pkg::*;
#(
   parameter int MAX_PENDING_SPACE = 16
) (
   input  logic        clock,
   input  logic        reset,
   csvft_req_if.sink   req_chan,
   csvft_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp_data;

   csvft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   csvft_dp #(
      .MAX_PENDING_SPACE (MAX_PENDING_SPACE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_kind      (req_chan.kind),
      .req_char_byte (req_chan.char_byte),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_data)
   );

   assign rsp_chan.out_byte       = rsp_data.out_byte;
   assign rsp_chan.byte_valid     = rsp_data.byte_valid;
   assign rsp_chan.field_end      = rsp_data.field_end;
   assign rsp_chan.line_end       = rsp_data.line_end;
   assign rsp_chan.space_overflow = rsp_data.space_overflow;
   assign rsp_chan.last           = rsp_data.last;

endmodule
